// File: sv/lbi_pkg.sv
// Shared types, constants and a helper function for the border search block.
`timescale 1ns / 1ps
package lbi_pkg;

  localparam int MAX_LEN_DEFAULT = 4096;
  localparam int HASH_W          = 64;
  localparam int QUEUE_DEPTH     = 2;
  localparam logic [HASH_W-1:0] CHAR_OFFSET = 64'd96;

  // One classified character on its way from the front to the back.
  typedef struct packed {
    logic [7:0] code;
    logic       store;
    logic       last;
    logic       trunc;
  } q_item_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_RD_LEN,
    B_RD_M,
    B_RD_SUF,
    B_SUF_X,
    B_MUL0,
    B_MUL1,
    B_MUL2,
    B_CMP,
    B_RD_B,
    B_RD_A,
    B_IN_X,
    B_EMIT
  } back_state_t;

  // Multiplication by the hash base 131 = 128 + 2 + 1, wrapping.
  function automatic logic [HASH_W-1:0] mul131(input logic [HASH_W-1:0] v);
    mul131 = (v << 7) + (v << 1) + v;
  endfunction

endpackage

// File: sv/longest_border_also_inside_top.sv
// Top level of the rolling-hash border search block.
`timescale 1ns / 1ps
// A string enters one character per transfer on char_code, with last_char
// high on its final character. A character is transferred at a rising edge
// where start is high and busy is low. Characters beyond MAX_LEN are dropped
// and reported through truncated; a dropped final character still ends the
// string.
// Characters move through a two-entry queue and are hashed into the prefix
// and power RAMs at one per cycle while no search runs, so a string loads at
// one character a cycle. After the last character the search walks the stored
// hashes: for each length it tests the suffix and, if that matches, each inner
// start in turn; each test reads the prefix RAM, multiplies in parts and
// compares, as set by the single 32-bit multiplier and the one read port of
// the prefix RAM. Busy stays high once the queue fills behind a running search.
// The result appears for exactly one cycle with done high; the receiver
// cannot hold it off. Strings shorter than three characters give found = 0.
// Reset clears the counts, the queue and the sequencer; RAM contents are
// left as they are and only entries of the current string are ever read.
module longest_border_also_inside_top #(
  parameter int MAX_LEN = lbi_pkg::MAX_LEN_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [7:0]                     char_code,
  input  logic                           last_char,
  output logic                           done,
  output logic                           found,
  output logic [$clog2(MAX_LEN + 1)-1:0] border_length,
  output logic                           truncated
);
  import lbi_pkg::*;

  q_item_t in_item;
  q_item_t head_item;
  logic    accept;
  logic    q_pop;
  logic    q_not_empty;
  logic    q_full;

  assign busy   = q_full;
  assign accept = start && !q_full;

  lbi_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (char_code),
    .last_char (last_char),
    .item      (in_item)
  );

  lbi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_item (in_item),
    .pop       (q_pop),
    .head_item (head_item),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  lbi_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_not_empty),
    .q_item        (head_item),
    .q_pop         (q_pop),
    .done          (done),
    .found         (found),
    .border_length (border_length),
    .truncated     (truncated)
  );

endmodule

// File: sv/lbi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lbi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4097
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/lbi_queue.sv
// Short first-in first-out queue of classified characters.
`timescale 1ns / 1ps
module lbi_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lbi_pkg::q_item_t push_item,
  input  logic             pop,
  output lbi_pkg::q_item_t head_item,
  output logic             not_empty,
  output logic             full
);
  import lbi_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  q_item_t         slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [NW-1:0]   fill;

  assign head_item = slots[rd_ptr];
  assign not_empty = (fill != '0);
  assign full      = (fill == NW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + NW'(1);
        2'b01:   fill <= fill - NW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: sv/lbi_front.sv
// Front end: accepts characters and classifies them as stored or dropped.
`timescale 1ns / 1ps
module lbi_front #(
  parameter int MAX_LEN = lbi_pkg::MAX_LEN_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       char_code,
  input  logic             last_char,
  output lbi_pkg::q_item_t item
);
  import lbi_pkg::*;

  localparam int CW = $clog2(MAX_LEN + 1);

  logic [CW-1:0] cnt;
  logic          ovf;
  logic          store;

  assign store      = (cnt < CW'(MAX_LEN));
  assign item.code  = char_code;
  assign item.store = store;
  assign item.last  = last_char;
  assign item.trunc = ovf | ~store;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else if (accept) begin
      if (last_char) begin
        cnt <= '0;
        ovf <= 1'b0;
      end else begin
        cnt <= cnt + CW'(store);
        ovf <= ovf | ~store;
      end
    end
  end

endmodule

// File: sv/lbi_back.sv
// Back end: hashes stored characters into RAM and runs the border search.
`timescale 1ns / 1ps
module lbi_back #(
  parameter int MAX_LEN = lbi_pkg::MAX_LEN_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  lbi_pkg::q_item_t                 q_item,
  output logic                             q_pop,
  output logic                             done,
  output logic                             found,
  output logic [$clog2(MAX_LEN + 1)-1:0]   border_length,
  output logic                             truncated
);
  import lbi_pkg::*;

  localparam int CW    = $clog2(MAX_LEN + 1);
  localparam int DEPTH = MAX_LEN + 1;

  back_state_t       state;
  back_state_t       state_next;

  logic [CW-1:0]     widx;
  logic [HASH_W-1:0] h_prev;
  logic [HASH_W-1:0] p_prev;
  logic [CW-1:0]     len;
  logic              ovf;
  logic [CW-1:0]     m;
  logic [CW-1:0]     s;
  logic [CW-1:0]     answer;
  logic              chk_inner;
  logic [HASH_W-1:0] hlen;
  logic [HASH_W-1:0] head;
  logic [HASH_W-1:0] pw;
  logic [HASH_W-1:0] x;
  logic [HASH_W-1:0] hb;
  logic [HASH_W-1:0] acc;

  logic [HASH_W-1:0] hash_new;
  logic [HASH_W-1:0] power_new;
  logic [CW-1:0]     len_new;
  logic              we;
  logic [CW-1:0]     h_raddr;
  logic [CW-1:0]     p_raddr;
  logic [HASH_W-1:0] h_rdata;
  logic [HASH_W-1:0] p_rdata;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       prod;
  logic              match;
  logic              last_start;

  assign hash_new   = mul131(h_prev) + ({56'b0, q_item.code} - CHAR_OFFSET);
  assign power_new  = mul131(p_prev);
  assign len_new    = widx + CW'(q_item.store);
  assign match      = ((hb - acc) == head);
  assign last_start = (s == len - m);
  assign prod       = mul_a * mul_b;

  assign found         = (answer != '0);
  assign border_length = answer;
  assign truncated     = ovf;

  lbi_ram #(.WIDTH(HASH_W), .DEPTH(DEPTH)) u_prefix_ram (
    .clk   (clk),
    .we    (we),
    .waddr (widx + CW'(1)),
    .wdata (hash_new),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  lbi_ram #(.WIDTH(HASH_W), .DEPTH(DEPTH)) u_power_ram (
    .clk   (clk),
    .we    (we),
    .waddr (widx + CW'(1)),
    .wdata (power_new),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_valid && q_item.last) begin
          state_next = (len_new >= CW'(3)) ? B_RD_LEN : B_EMIT;
        end
      end
      B_RD_LEN: state_next = B_RD_M;
      B_RD_M:   state_next = B_RD_SUF;
      B_RD_SUF: state_next = B_SUF_X;
      B_SUF_X:  state_next = B_MUL0;
      B_MUL0:   state_next = B_MUL1;
      B_MUL1:   state_next = B_MUL2;
      B_MUL2:   state_next = B_CMP;
      B_CMP: begin
        if (match) begin
          state_next = chk_inner ? B_EMIT : B_RD_B;
        end else if (!chk_inner || last_start) begin
          state_next = (m == CW'(1)) ? B_EMIT : B_RD_M;
        end else begin
          state_next = B_RD_B;
        end
      end
      B_RD_B:   state_next = B_RD_A;
      B_RD_A:   state_next = B_IN_X;
      B_IN_X:   state_next = B_MUL0;
      B_EMIT:   state_next = B_IDLE;
      default:  state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop   = 1'b0;
    we      = 1'b0;
    h_raddr = '0;
    p_raddr = '0;
    done    = 1'b0;
    unique case (state)
      B_IDLE: begin
        q_pop = q_valid;
        we    = q_valid && q_item.store;
      end
      B_RD_LEN: h_raddr = len;
      B_RD_M: begin
        h_raddr = m;
        p_raddr = m;
      end
      B_RD_SUF: h_raddr = len - m;
      B_RD_B:   h_raddr = s + m - CW'(1);
      B_RD_A:   h_raddr = s - CW'(1);
      B_EMIT:   done = 1'b1;
      default: ;
    endcase
  end

  // The low 64 bits of the product are built from three 32-bit partial products.
  always_comb begin
    unique case (state)
      B_MUL1: begin
        mul_a = x[31:0];
        mul_b = pw[63:32];
      end
      B_MUL2: begin
        mul_a = x[63:32];
        mul_b = pw[31:0];
      end
      default: begin
        mul_a = x[31:0];
        mul_b = pw[31:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      widx   <= '0;
      h_prev <= '0;
      p_prev <= {{(HASH_W-1){1'b0}}, 1'b1};
    end else begin
      state <= state_next;
      if (state == B_IDLE && q_valid && q_item.store) begin
        widx   <= widx + CW'(1);
        h_prev <= hash_new;
        p_prev <= power_new;
      end
      if (state == B_EMIT) begin
        widx   <= '0;
        h_prev <= '0;
        p_prev <= {{(HASH_W-1){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (q_valid && q_item.last) begin
          len    <= len_new;
          ovf    <= q_item.trunc;
          m      <= len_new - CW'(2);
          answer <= '0;
        end
      end
      B_RD_M: begin
        // The whole-string hash arrives only on the first length tried.
        if (m == len - CW'(2)) begin
          hlen <= h_rdata;
        end
      end
      B_RD_SUF: begin
        head <= h_rdata;
        pw   <= p_rdata;
      end
      B_SUF_X: begin
        x         <= h_rdata;
        hb        <= hlen;
        chk_inner <= 1'b0;
      end
      B_MUL0: acc <= prod;
      B_MUL1: acc <= acc + {prod[31:0], 32'b0};
      B_MUL2: acc <= acc + {prod[31:0], 32'b0};
      B_CMP: begin
        if (match) begin
          if (chk_inner) begin
            answer <= m;
          end else begin
            s <= CW'(2);
          end
        end else if (!chk_inner || last_start) begin
          m <= m - CW'(1);
        end else begin
          s <= s + CW'(1);
        end
      end
      B_RD_A: hb <= h_rdata;
      B_IN_X: begin
        x         <= h_rdata;
        chk_inner <= 1'b1;
      end
      default: ;
    endcase
  end

  a_inner_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == B_RD_B) |-> (({1'b0, s} + {1'b0, m}) <= {1'b0, len}))
    else $error("inner start runs past the end of the string");

  a_answer_bound: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (({1'b0, answer} + (CW+1)'(2)) <= {1'b0, len}))
    else $error("reported border is longer than allowed");

  a_store_fits: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_item.store) |-> (widx < CW'(MAX_LEN)))
    else $error("front and back disagree on the stored character count");

endmodule

// File: dv/longest_border_also_inside_checker.sv
// Checker that predicts the border search results and compares them with the block.
`timescale 1ns / 1ps
module longest_border_also_inside_checker #(
  parameter int MAX_LEN = lbi_pkg::MAX_LEN_DEFAULT,
  parameter int LEN_W   = $clog2(MAX_LEN + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic [7:0]       char_code,
  input  logic             last_char,
  input  logic             done,
  input  logic             found,
  input  logic [LEN_W-1:0] border_length,
  input  logic             truncated,
  output int               fail_count,
  output int               pending
);
  import lbi_pkg::*;

  localparam logic [63:0] HASH_BASE = 64'd131;

  typedef struct packed {
    logic             found;
    logic [LEN_W-1:0] length;
    logic             trunc;
  } border_t;

  logic [63:0] hash_mem [0:MAX_LEN];
  logic [63:0] pow_mem  [0:MAX_LEN];
  int          stored_chars  = 0;
  bit          chars_dropped = 0;
  border_t     border_q[$];
  int          errors = 0;

  // Hash of positions a..b of the stored string, both inclusive.
  function automatic logic [63:0] span_of(input int a, input int b);
    return hash_mem[b] - hash_mem[a - 1] * pow_mem[b - a + 1];
  endfunction

  function automatic int longest_inner_border(input int n);
    logic [63:0] head;
    for (int m = n - 2; m >= 1; m--) begin
      head = span_of(1, m);
      if (head == span_of(n - m + 1, n)) begin
        for (int s = 2; s <= n - m; s++)
          if (span_of(s, s + m - 1) == head) return m;
      end
    end
    return 0;
  endfunction

  always @(posedge clk) begin : predict
    border_t want;
    int      len;
    if (rst) begin
      stored_chars  = 0;
      chars_dropped = 0;
      hash_mem[0]   = 64'd0;
      pow_mem[0]    = 64'd1;
      border_q.delete();
    end else begin
      // Results are checked before this edge's transfer is predicted, so the
      // oldest expectation is always the one that is compared.
      if (done) begin
        if (border_q.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: found=%0d border_length=%0d truncated=%0d",
                   $time, found, border_length, truncated);
        end else begin
          want = border_q.pop_front();
          if (found !== want.found) begin
            errors++;
            $display("%0t: found expected %0d actual %0d", $time, want.found, found);
          end
          if (border_length !== want.length) begin
            errors++;
            $display("%0t: border_length expected %0d actual %0d",
                     $time, want.length, border_length);
          end
          if (truncated !== want.trunc) begin
            errors++;
            $display("%0t: truncated expected %0d actual %0d", $time, want.trunc, truncated);
          end
        end
      end
      if (start && !busy) begin
        if (stored_chars < MAX_LEN) begin
          hash_mem[stored_chars + 1] = hash_mem[stored_chars] * HASH_BASE
                                       + ({56'd0, char_code} - CHAR_OFFSET);
          pow_mem[stored_chars + 1]  = pow_mem[stored_chars] * HASH_BASE;
          stored_chars++;
        end else begin
          chars_dropped = 1;
        end
        if (last_char) begin
          len          = longest_inner_border(stored_chars);
          want.found   = (len != 0);
          want.length  = LEN_W'(len);
          want.trunc   = chars_dropped;
          border_q.push_back(want);
          stored_chars  = 0;
          chars_dropped = 0;
        end
      end
    end
    fail_count <= errors;
    pending    <= border_q.size();
  end

endmodule

// File: dv/longest_border_also_inside_top_tb.sv
// Testbench top: drives strings into the border search block and gives the verdict.
`timescale 1ns / 1ps
module longest_border_also_inside_top_tb;
  import lbi_pkg::*;

  localparam int         MAX_LEN      = MAX_LEN_DEFAULT;
  localparam int         LEN_W        = $clog2(MAX_LEN + 1);
  localparam int         IDLE_LIMIT   = 200000;
  localparam int         RANDOM_CHARS = 1700;
  localparam int         TAIL_CYCLES  = 200;
  localparam logic [7:0] LETTER_A     = 8'h61;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  logic [7:0]       char_code = 8'd0;
  logic             last_char = 1'b0;
  logic             busy;
  logic             done;
  logic             found;
  logic [LEN_W-1:0] border_length;
  logic             truncated;

  int         fail_count;
  int         pending;
  int         idle_cycles  = 0;
  int         strings_sent = 0;
  int         chars_sent   = 0;
  int         random_chars = 0;
  bit         calm         = 0;
  logic [7:0] word_buf[$];

  always #5 clk = ~clk;

  longest_border_also_inside_top #(.MAX_LEN(MAX_LEN)) DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .char_code     (char_code),
    .last_char     (last_char),
    .done          (done),
    .found         (found),
    .border_length (border_length),
    .truncated     (truncated)
  );

  longest_border_also_inside_checker #(.MAX_LEN(MAX_LEN)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .char_code     (char_code),
    .last_char     (last_char),
    .done          (done),
    .found         (found),
    .border_length (border_length),
    .truncated     (truncated),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic pause_random();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    if (r < 55) gap = 0;
    else if (r < 88) gap = $urandom_range(1, 3);
    else if (r < 98) gap = $urandom_range(4, 20);
    else gap = $urandom_range(40, 200);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_char(input logic [7:0] c, input logic l);
    start     <= 1'b1;
    char_code <= c;
    last_char <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    chars_sent++;
    if (!calm) pause_random();
  endtask

  task automatic send_word();
    foreach (word_buf[i]) send_char(word_buf[i], i == word_buf.size() - 1);
    strings_sent++;
    word_buf.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) word_buf.push_back(s[i]);
  endtask

  // The count of outstanding results is a registered copy of the checker's queue size.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic build_random();
    int         r;
    int         n;
    int         mode;
    int         plen;
    logic [7:0] pat [4];
    r = $urandom_range(0, 99);
    if (r < 80) n = $urandom_range(1, 12);
    else if (r < 97) n = $urandom_range(13, 30);
    else n = $urandom_range(31, 48);
    mode = $urandom_range(0, 99);
    plen = $urandom_range(1, 4);
    for (int k = 0; k < 4; k++) pat[k] = LETTER_A + 8'($urandom_range(0, 2));
    for (int i = 0; i < n; i++) begin
      if (mode < 45) word_buf.push_back(LETTER_A + 8'($urandom_range(0, 1)));
      else if (mode < 75) word_buf.push_back(LETTER_A + 8'($urandom_range(0, 2)));
      else if (mode < 90) begin
        // Repeated pattern with the odd stray letter gives long borders.
        if ($urandom_range(0, 9) == 0) word_buf.push_back(LETTER_A + 8'($urandom_range(0, 3)));
        else word_buf.push_back(pat[i % plen]);
      end else word_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Short strings, extreme bytes and a few known borders.
    add_text("a");
    send_word();
    wait_drained();
    add_text("ab");
    send_word();
    add_text("aaa");
    send_word();
    add_text("abcab");
    send_word();
    add_text("abcabcab");
    send_word();
    word_buf = '{8'h00, 8'hFF, 8'h00};
    send_word();
    word_buf = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_word();
    add_text("abab");
    send_word();

    while (random_chars < RANDOM_CHARS) begin
      calm = ($urandom_range(0, 3) == 0);
      build_random();
      random_chars += word_buf.size();
      if ($urandom_range(0, 39) == 0) wait_drained();
      send_word();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("summary: %0d strings and %0d characters transferred", strings_sent, chars_sent);
    $display("summary: short, periodic, full-byte and random strings with random pauses");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
sv/lbi_pkg.sv
sv/lbi_ram.sv
sv/lbi_queue.sv
sv/lbi_front.sv
sv/lbi_back.sv
sv/longest_border_also_inside_top.sv
dv/longest_border_also_inside_checker.sv
dv/longest_border_also_inside_top_tb.sv
